[src/lclr_pkg.sv]
// Shared constants, types and helpers for the character LCD line refresh unit.
package lclr_pkg;

   localparam int LINES       = 4;
   localparam int LINE_LENGTH = 16;
   localparam int HALF_LINE   = LINE_LENGTH >> 1;

   localparam int COL_W     = $clog2(LINE_LENGTH);
   localparam int LEN_W     = $clog2(LINE_LENGTH + 1);
   localparam int RAM_DEPTH = LINES * LINE_LENGTH;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int PROD_W    = ADDR_W + 3;

   localparam int NUM_CFG   = 8;
   localparam int CFG_IDX_W = 3;
   localparam int DDRAM_W   = 7;
   localparam int MID_BASE  = 4;

   localparam logic OP_STRING = 1'b0;
   localparam logic OP_POLL   = 1'b1;

   localparam logic [1:0] ALIGN_LEFT   = 2'd0;
   localparam logic [1:0] ALIGN_CENTER = 2'd1;
   localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

   localparam logic [1:0] RS_LEFT_CMD    = 2'd0;
   localparam logic [1:0] RS_FIRST_HALF  = 2'd1;
   localparam logic [1:0] RS_MID_CMD     = 2'd2;
   localparam logic [1:0] RS_SECOND_HALF = 2'd3;

   localparam logic [2:0] IDLE_LINE    = 3'd7;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;

   localparam logic [DDRAM_W-1:0] CFG_RESET [NUM_CFG] = '{
      7'd0, 7'd64, 7'd16, 7'd80, 7'd8, 7'd72, 7'd24, 7'd88
   };

   typedef struct packed {
      logic       is_poll;
      logic       commit;
      logic       line_ok;
      logic [1:0] line;
      logic [1:0] align;
      logic [7:0] ch;
      logic       busy;
   } lclr_cmd_type;

   typedef struct packed {
      logic [7:0] lcd_byte;
      logic       rs;
      logic       done;
   } lclr_rsp_type;

   function automatic logic [ADDR_W-1:0] ram_addr(input logic [1:0] line,
                                                  input logic [COL_W-1:0] col);
      logic [PROD_W-1:0] full;
      full = PROD_W'(line) * PROD_W'(LINE_LENGTH) + PROD_W'(col);
      return full[ADDR_W-1:0];
   endfunction

endpackage

[src/lclr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lclr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/lclr_front.sv]
// Front end: accepts request transactions, decodes them and queues commands.
module lclr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_op,
   input  logic [1:0]             req_line_number,
   input  logic [1:0]             req_alignment,
   input  logic [7:0]             req_text_char,
   input  logic                   req_last_char,
   input  logic                   req_display_busy,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output lclr_pkg::lclr_cmd_type cmd
);

   lclr_pkg::lclr_cmd_type q_ff [2];
   logic                   wr_ff, wr_in;
   logic                   rd_ff, rd_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic                   push, pop;
   lclr_pkg::lclr_cmd_type dec;

   always_comb begin
      dec.is_poll = (req_op == lclr_pkg::OP_POLL);
      dec.commit  = (req_op == lclr_pkg::OP_STRING) && req_last_char;
      dec.line_ok = ({1'b0, req_line_number} < 3'(lclr_pkg::LINES));
      dec.line    = req_line_number;
      dec.align   = req_alignment;
      dec.ch      = req_text_char;
      dec.busy    = req_display_busy;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[src/lclr_back.sv]
// Back end: string staging, line commit walk, refresh sequencer and result queue.
module lclr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  lclr_pkg::lclr_cmd_type        cmd,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lclr_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [lclr_pkg::DDRAM_W-1:0]   csr_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_lcd_byte,
   output logic                          rsp_register_select,
   output logic                          rsp_line_done
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_COMMIT = 3'b010,
      ST_READ   = 3'b100
   } lclr_state_type;

   localparam int LEN_W = lclr_pkg::LEN_W;
   localparam int COL_W = lclr_pkg::COL_W;

   logic [lclr_pkg::DDRAM_W-1:0] cfg_ff [lclr_pkg::NUM_CFG];
   logic [7:0]                   staging_ff [lclr_pkg::LINE_LENGTH];
   logic [LEN_W-1:0]             len_ff, len_in;
   logic                         ended_ff, ended_in;
   logic [lclr_pkg::LINES-1:0]   pending_ff, pending_in;
   logic [2:0]                   active_ff, active_in;
   logic [1:0]                   stage_ff, stage_in;
   logic [LEN_W-1:0]             cidx_ff, cidx_in;
   lclr_state_type               state_ff, state_in;
   logic [COL_W-1:0]             walk_ff, walk_in;
   logic [1:0]                   cline_ff, cline_in;
   logic [LEN_W-1:0]             clen_ff, clen_in;
   logic [LEN_W-1:0]             lead_ff, lead_in;
   logic                         done_ff, done_in;

   lclr_pkg::lclr_rsp_type       oq_ff [2];
   logic                         oq_wr_ff, oq_rd_ff;
   logic [1:0]                   oq_cnt_ff;
   logic                         oq_full, oq_pop;
   logic                         push;
   lclr_pkg::lclr_rsp_type       push_data;

   logic                         stg_we;
   logic [LEN_W-1:0]             staged_len;
   logic [LEN_W-1:0]             cidx_nxt;
   logic [LEN_W-1:0]             walk_ext, walk_off;
   logic [2:0]                   act;
   logic [lclr_pkg::LINES-1:0]   pend;
   logic [1:0]                   stg;

   logic                         ram_we, ram_re;
   logic [lclr_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [7:0]                   ram_wdata, ram_rdata;

   lclr_ram #(
      .WIDTH (8),
      .DEPTH (lclr_pkg::RAM_DEPTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign oq_full   = (oq_cnt_ff == 2'd2);
   assign oq_pop    = rsp_pop && (oq_cnt_ff != 2'd0);

   assign rsp_empty           = (oq_cnt_ff == 2'd0);
   assign rsp_lcd_byte        = oq_ff[oq_rd_ff].lcd_byte;
   assign rsp_register_select = oq_ff[oq_rd_ff].rs;
   assign rsp_line_done       = oq_ff[oq_rd_ff].done;

   // length after staging the current character (used by a commit on the same item)
   always_comb begin
      if (!ended_ff && (cmd.ch != 8'd0) && (len_ff < LEN_W'(lclr_pkg::LINE_LENGTH))) begin
         staged_len = len_ff + LEN_W'(1);
      end else begin
         staged_len = len_ff;
      end
   end

   assign cidx_nxt = cidx_ff + LEN_W'(1);
   assign walk_ext = LEN_W'(walk_ff);
   assign walk_off = walk_ext - lead_ff;

   always_comb begin
      len_in     = len_ff;
      ended_in   = ended_ff;
      pending_in = pending_ff;
      active_in  = active_ff;
      stage_in   = stage_ff;
      cidx_in    = cidx_ff;
      state_in   = state_ff;
      walk_in    = walk_ff;
      cline_in   = cline_ff;
      clen_in    = clen_ff;
      lead_in    = lead_ff;
      done_in    = done_ff;
      cmd_ready  = 1'b0;
      stg_we     = 1'b0;
      push       = 1'b0;
      push_data  = '0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = '0;
      ram_raddr  = '0;
      ram_wdata  = lclr_pkg::SPACE_CHAR;
      act        = active_ff;
      pend       = pending_ff;
      stg        = stage_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !oq_full) begin
               cmd_ready = 1'b1;
               if (!cmd.is_poll) begin
                  if (!ended_ff) begin
                     if (cmd.ch == 8'd0) begin
                        ended_in = 1'b1;
                     end else if (len_ff < LEN_W'(lclr_pkg::LINE_LENGTH)) begin
                        stg_we = 1'b1;
                        len_in = staged_len;
                     end
                  end
                  if (cmd.commit) begin
                     len_in   = '0;
                     ended_in = 1'b0;
                     if (cmd.line_ok) begin
                        clen_in  = staged_len;
                        cline_in = cmd.line;
                        walk_in  = '0;
                        state_in = ST_COMMIT;
                        case (cmd.align)
                           lclr_pkg::ALIGN_CENTER: begin
                              lead_in = (LEN_W'(lclr_pkg::LINE_LENGTH) - staged_len) >> 1;
                           end
                           lclr_pkg::ALIGN_RIGHT: begin
                              lead_in = LEN_W'(lclr_pkg::LINE_LENGTH) - staged_len;
                           end
                           default: begin
                              lead_in = '0;
                           end
                        endcase
                        pending_in = pending_ff | lclr_pkg::LINES'(1 << cmd.line);
                        if (active_ff == {1'b0, cmd.line}) begin
                           stage_in = lclr_pkg::RS_LEFT_CMD;
                        end
                     end
                  end
               end else begin
                  // pick the lowest pending line when nothing is active
                  if ((active_ff == lclr_pkg::IDLE_LINE) && (pending_ff != '0)) begin
                     for (int k = lclr_pkg::LINES - 1; k >= 0; k--) begin
                        if (pending_ff[k]) begin
                           act = 3'(k);
                        end
                     end
                     pend = pending_ff & ~lclr_pkg::LINES'(1 << act);
                     stg  = lclr_pkg::RS_LEFT_CMD;
                  end
                  active_in  = act;
                  pending_in = pend;
                  stage_in   = stg;
                  if ((act != lclr_pkg::IDLE_LINE) && !cmd.busy) begin
                     case (stg)
                        lclr_pkg::RS_LEFT_CMD: begin
                           push               = 1'b1;
                           push_data.lcd_byte = lclr_pkg::CMD_SET_ADDR |
                                                {1'b0, cfg_ff[{1'b0, act[1:0]}]};
                           stage_in           = lclr_pkg::RS_FIRST_HALF;
                           cidx_in            = '0;
                        end
                        lclr_pkg::RS_MID_CMD: begin
                           push               = 1'b1;
                           push_data.lcd_byte = lclr_pkg::CMD_SET_ADDR |
                              {1'b0, cfg_ff[3'(lclr_pkg::MID_BASE) + {1'b0, act[1:0]}]};
                           stage_in           = lclr_pkg::RS_SECOND_HALF;
                        end
                        lclr_pkg::RS_FIRST_HALF: begin
                           ram_re    = 1'b1;
                           ram_raddr = lclr_pkg::ram_addr(act[1:0], cidx_ff[COL_W-1:0]);
                           cidx_in   = cidx_nxt;
                           done_in   = 1'b0;
                           state_in  = ST_READ;
                           if (cidx_nxt >= LEN_W'(lclr_pkg::HALF_LINE)) begin
                              stage_in = lclr_pkg::RS_MID_CMD;
                           end
                        end
                        default: begin
                           ram_re    = 1'b1;
                           ram_raddr = lclr_pkg::ram_addr(act[1:0], cidx_ff[COL_W-1:0]);
                           cidx_in   = cidx_nxt;
                           done_in   = 1'b0;
                           state_in  = ST_READ;
                           if (cidx_nxt >= LEN_W'(lclr_pkg::LINE_LENGTH)) begin
                              active_in = lclr_pkg::IDLE_LINE;
                              done_in   = 1'b1;
                           end
                        end
                     endcase
                  end
               end
            end
         end
         ST_COMMIT: begin
            ram_we    = 1'b1;
            ram_waddr = lclr_pkg::ram_addr(cline_ff, walk_ff);
            if ((walk_ext >= lead_ff) && (walk_off < clen_ff)) begin
               ram_wdata = staging_ff[walk_off[COL_W-1:0]];
            end
            walk_in = walk_ff + COL_W'(1);
            if (walk_ff == COL_W'(lclr_pkg::LINE_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            push               = 1'b1;
            push_data.lcd_byte = ram_rdata;
            push_data.rs       = 1'b1;
            push_data.done     = done_ff;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_we) begin
         staging_ff[len_ff[COL_W-1:0]] <= cmd.ch;
      end
      if (push) begin
         oq_ff[oq_wr_ff] <= push_data;
      end
      walk_ff  <= walk_in;
      cline_ff <= cline_in;
      clen_ff  <= clen_in;
      lead_ff  <= lead_in;
      done_ff  <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lclr_pkg::NUM_CFG; i++) begin
            cfg_ff[i] <= lclr_pkg::CFG_RESET[i];
         end
         len_ff     <= '0;
         ended_ff   <= 1'b0;
         pending_ff <= '0;
         active_ff  <= lclr_pkg::IDLE_LINE;
         stage_ff   <= lclr_pkg::RS_LEFT_CMD;
         cidx_ff    <= '0;
         state_ff   <= ST_IDLE;
         oq_wr_ff   <= 1'b0;
         oq_rd_ff   <= 1'b0;
         oq_cnt_ff  <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_ff[csr_index] <= csr_data;
         end
         len_ff     <= len_in;
         ended_ff   <= ended_in;
         pending_ff <= pending_in;
         active_ff  <= active_in;
         stage_ff   <= stage_in;
         cidx_ff    <= cidx_in;
         state_ff   <= state_in;
         oq_wr_ff   <= push ? ~oq_wr_ff : oq_wr_ff;
         oq_rd_ff   <= oq_pop ? ~oq_rd_ff : oq_rd_ff;
         oq_cnt_ff  <= oq_cnt_ff + {1'b0, push} - {1'b0, oq_pop};
      end
   end

`ifndef SYNTH
   a_active_legal: assert property (@(posedge clock) disable iff (reset)
      (active_ff == lclr_pkg::IDLE_LINE) || (active_ff < 3'(lclr_pkg::LINES)))
      else $error("active line out of range");

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= 2'd2)
      else $error("result queue overflow");

   a_read_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_IDLE))
      else $error("read state not entered from idle");

   a_read_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !oq_full)
      else $error("no result slot for read data");

   a_cidx_bound: assert property (@(posedge clock) disable iff (reset)
      (active_ff != lclr_pkg::IDLE_LINE) |-> (cidx_ff <= LEN_W'(lclr_pkg::LINE_LENGTH)))
      else $error("character index past line end");
`endif

endmodule

[src/char_lcd_line_refresh_unit.sv]
// Top level of the character LCD line refresh unit.
// Usage:
//   req_* is a queue input: an item is taken when req_push is high and req_full low.
//   op 0 items stage characters of a string for one line; the item with last_char
//   set commits the line, stored aligned and space padded, and marks it pending.
//   op 1 items poll the refresh; each poll with display_busy low sends one byte
//   (address command or text byte) of the active line, else of the lowest pending one, if any.
//   rsp_* is a queue output: the oldest byte is shown while rsp_empty is low and
//   is taken when rsp_pop is high.
//   csr_* writes the eight DDRAM address registers; csr_ready is always high.
// Timing: a two-entry command queue feeds the back end. A commit walks the whole
//   line, writing one line RAM location per cycle; a poll for a text byte also
//   passes through a read state for the registered line RAM read. A command byte
//   is visible in the cycle after acceptance; a text byte is first read into the
//   line RAM read register and then written into the result queue.
// Reset: address registers return to defaults, no line pending or active, queues empty.
// Stalls: results wait in a two-entry queue; when it is full the back end stops,
//   the command queue fills and req_full rises.
module char_lcd_line_refresh_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_op,
   input  logic [1:0]                    req_line_number,
   input  logic [1:0]                    req_alignment,
   input  logic [7:0]                    req_text_char,
   input  logic                          req_last_char,
   input  logic                          req_display_busy,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_lcd_byte,
   output logic                          rsp_register_select,
   output logic                          rsp_line_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lclr_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [lclr_pkg::DDRAM_W-1:0]   csr_data
);

   logic                   cmd_valid;
   logic                   cmd_ready;
   lclr_pkg::lclr_cmd_type cmd;

   lclr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op           (req_op),
      .req_line_number  (req_line_number),
      .req_alignment    (req_alignment),
      .req_text_char    (req_text_char),
      .req_last_char    (req_last_char),
      .req_display_busy (req_display_busy),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   lclr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_valid),
      .cmd_ready           (cmd_ready),
      .cmd                 (cmd),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_lcd_byte        (rsp_lcd_byte),
      .rsp_register_select (rsp_register_select),
      .rsp_line_done       (rsp_line_done)
   );

endmodule
